@@ hdl/pbsd_pkg.sv @@
// Shared types and constants for the PackBits scanline decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package pbsd_pkg;

    localparam int unsigned MAX_WIDTH = 32768;

    localparam logic [15:0] LINE_WIDTH_RST = 16'd32768;
    localparam logic [16:0] WIDTH_CAP      = 17'(MAX_WIDTH);
    localparam logic [7:0]  CTRL_NOP       = 8'h80;
    localparam logic [8:0]  REP_BASE       = 9'd257;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CLIP  = 2'd1;
    localparam logic [1:0] ST_STRAY = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_CTRL = 4'b0010,
        PH_LIT  = 4'b0100,
        PH_REP  = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_REP = 2'b10
    } ctrl_state_t;

    typedef enum logic [2:0] {
        KIND_LINE,
        KIND_STRAY,
        KIND_CTRL,
        KIND_LIT,
        KIND_REP
    } kind_t;

    typedef struct packed {
        logic load_hold;
        logic step;
        logic rep_emit;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  has_result;
        logic  run_final;
    } stat_t;

endpackage

@@ hdl/pbsd_dp.sv @@
// Datapath of the PackBits scanline decoder: request holding register,
// scanline state, column and width checks, and the result register. Uses pbsd_pkg.
module pbsd_dp
    import pbsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        mode,
    input  logic [7:0]  packed_byte,
    input  logic [15:0] line_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte,
    output logic [1:0]  byte_count,
    output logic [14:0] column,
    output logic        last,
    output logic        line_done,
    output logic [1:0]  status
);

    logic        mode_reg;
    logic [7:0]  byte_reg;
    logic [15:0] lb_reg;
    logic [7:0]  rep_byte_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  run_reg, run_next;
    logic [15:0] budget_reg, budget_next;
    logic [15:0] col_reg, col_next;
    logic        done_reg, done_next;
    logic [15:0] width_reg;

    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [1:0]  count_reg, count_next;
    logic [14:0] column_reg, column_next;
    logic        last_reg, last_next;
    logic        line_done_reg, line_done_next;
    logic [1:0]  status_reg, status_next;

    kind_t       kind;
    logic        done_now;
    logic [16:0] width_eff;
    logic        emit_two;
    logic [7:0]  emit_b;
    logic        fit_one;
    logic        fit_two;
    logic [1:0]  e_cnt;
    logic        e_clip;
    logic [16:0] col_sum;
    logic [15:0] col_adv;

    assign cfg_ready = 1'b1;

    assign width_eff = ({1'b0, width_reg} > WIDTH_CAP) ? WIDTH_CAP : {1'b0, width_reg};
    assign done_now  = (budget_reg == 16'd1);

    always_comb
    begin
        priority if (!mode_reg)
            kind = KIND_LINE;
        else if (phase_reg == PH_IDLE || budget_reg == 16'd0)
            kind = KIND_STRAY;
        else if (phase_reg == PH_CTRL)
            kind = KIND_CTRL;
        else if (phase_reg == PH_LIT)
            kind = KIND_LIT;
        else
            kind = KIND_REP;
    end

    always_comb
    begin
        stat.kind      = kind;
        stat.run_final = (run_reg <= 8'd2);
        unique case (kind)
            KIND_LINE:  stat.has_result = (lb_reg == 16'd0);
            KIND_STRAY: stat.has_result = 1'b1;
            KIND_CTRL:  stat.has_result = done_now;
            KIND_LIT:   stat.has_result = 1'b1;
            KIND_REP:   stat.has_result = 1'b0;
            default:    stat.has_result = 1'b0;
        endcase
    end

    // Bytes at or past the width in effect are dropped; the column still advances.
    assign emit_two = cmd.rep_emit && (run_reg >= 8'd2);
    assign emit_b   = cmd.rep_emit ? rep_byte_reg : byte_reg;
    assign fit_one  = ({1'b0, col_reg} < width_eff);
    assign fit_two  = fit_one && emit_two && (({1'b0, col_reg} + 17'd1) < width_eff);
    assign e_cnt    = fit_two ? 2'd2 : (fit_one ? 2'd1 : 2'd0);
    assign e_clip   = emit_two ? !fit_two : !fit_one;
    assign col_sum  = {1'b0, col_reg} + (emit_two ? 17'd2 : 17'd1);
    assign col_adv  = col_sum[16] ? 16'hFFFF : col_sum[15:0];

    always_comb
    begin
        phase_next     = phase_reg;
        run_next       = run_reg;
        budget_next    = budget_reg;
        col_next       = col_reg;
        done_next      = done_reg;
        first_next     = 8'd0;
        second_next    = 8'd0;
        count_next     = 2'd0;
        column_next    = col_reg[14:0];
        last_next      = 1'b1;
        line_done_next = 1'b0;
        status_next    = ST_OK;

        if (cmd.step)
        begin
            unique case (kind)
                KIND_LINE:
                begin
                    budget_next    = lb_reg;
                    col_next       = 16'd0;
                    run_next       = 8'd0;
                    phase_next     = (lb_reg == 16'd0) ? PH_IDLE : PH_CTRL;
                    column_next    = 15'd0;
                    line_done_next = 1'b1;
                end
                KIND_STRAY:
                begin
                    phase_next  = PH_IDLE;
                    status_next = ST_STRAY;
                end
                KIND_CTRL:
                begin
                    budget_next = budget_reg - 16'd1;
                    if (byte_reg < CTRL_NOP)
                    begin
                        run_next   = byte_reg + 8'd1;
                        phase_next = PH_LIT;
                    end
                    else if (byte_reg > CTRL_NOP)
                    begin
                        run_next   = 8'(REP_BASE - {1'b0, byte_reg});
                        phase_next = PH_REP;
                    end
                    if (done_now)
                    begin
                        run_next   = 8'd0;
                        phase_next = PH_IDLE;
                    end
                    line_done_next = 1'b1;
                end
                KIND_LIT:
                begin
                    budget_next    = budget_reg - 16'd1;
                    first_next     = fit_one ? emit_b : 8'd0;
                    count_next     = e_cnt;
                    status_next    = e_clip ? ST_CLIP : ST_OK;
                    line_done_next = done_now;
                    col_next       = col_adv;
                    run_next       = run_reg - 8'd1;
                    if (run_reg == 8'd1)
                        phase_next = PH_CTRL;
                    if (done_now)
                    begin
                        run_next   = 8'd0;
                        phase_next = PH_IDLE;
                    end
                end
                KIND_REP:
                begin
                    budget_next = budget_reg - 16'd1;
                    done_next   = done_now;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else if (cmd.rep_emit)
        begin
            first_next     = fit_one ? emit_b : 8'd0;
            second_next    = fit_two ? emit_b : 8'd0;
            count_next     = e_cnt;
            status_next    = e_clip ? ST_CLIP : ST_OK;
            last_next      = stat.run_final;
            line_done_next = stat.run_final && done_reg;
            col_next       = col_adv;
            run_next       = run_reg - (emit_two ? 8'd2 : 8'd1);
            if (stat.run_final)
            begin
                run_next   = 8'd0;
                phase_next = done_reg ? PH_IDLE : PH_CTRL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            run_reg    <= 8'd0;
            budget_reg <= 16'd0;
            col_reg    <= 16'd0;
            done_reg   <= 1'b0;
            width_reg  <= LINE_WIDTH_RST;
        end
        else
        begin
            phase_reg  <= phase_next;
            run_reg    <= run_next;
            budget_reg <= budget_next;
            col_reg    <= col_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
                width_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_hold)
        begin
            mode_reg <= mode;
            byte_reg <= packed_byte;
            lb_reg   <= line_bytes;
        end
        if (cmd.step && kind == KIND_REP)
            rep_byte_reg <= byte_reg;
        if (cmd.step || cmd.rep_emit)
        begin
            first_reg     <= first_next;
            second_reg    <= second_next;
            count_reg     <= count_next;
            column_reg    <= column_next;
            last_reg      <= last_next;
            line_done_reg <= line_done_next;
            status_reg    <= status_next;
        end
    end

    assign first_byte  = first_reg;
    assign second_byte = second_reg;
    assign byte_count  = count_reg;
    assign column      = column_reg;
    assign last        = last_reg;
    assign line_done   = line_done_reg;
    assign status      = status_reg;

endmodule

@@ hdl/pbsd_ctrl.sv @@
// Controller of the PackBits scanline decoder: request hold, result valid
// and the repeat-run sequencer. Uses pbsd_pkg; drives pbsd_dp through cmd_t.
module pbsd_ctrl
    import pbsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    output logic  result_valid,
    input  logic  result_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        hold_reg, hold_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd.step       = (state_reg == S_RUN) && hold_reg && out_free;
        cmd.rep_emit   = (state_reg == S_REP) && out_free;
        item_ready     = !hold_reg || cmd.step;
        cmd.load_hold  = item_valid && item_ready;
        hold_next      = cmd.load_hold ? 1'b1 : (cmd.step ? 1'b0 : hold_reg);

        unique case (state_reg)
            S_RUN:
            begin
                if (cmd.step)
                begin
                    out_valid_next = stat.has_result;
                    if (stat.kind == KIND_REP)
                        state_next = S_REP;
                end
            end
            S_REP:
            begin
                if (cmd.rep_emit)
                begin
                    out_valid_next = 1'b1;
                    if (stat.run_final)
                        state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |-> (!cmd.step && !cmd.rep_emit))
        else $error("pending result overwritten");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.rep_emit))
        else $error("step and repeat emit in the same cycle");

    a_rep_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.kind == KIND_REP) |=> (state_reg == S_REP && !result_valid))
        else $error("repeat run not entered");

    a_rep_leave: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rep_emit && stat.run_final) |=> (state_reg == S_RUN && result_valid))
        else $error("repeat run did not end with a result");

endmodule

@@ hdl/packbits_scanline_decoder.sv @@
// PackBits scanline decoder, top level.
// Instantiates pbsd_ctrl and pbsd_dp; uses pbsd_pkg.
//
// Requests enter on item_valid/item_ready: mode 0 starts a scanline with a
// packed byte budget in line_bytes, mode 1 carries one packed byte. Results
// leave on result_valid/result_ready with up to two expanded bytes each, their
// column, and last, line_done and status flags. The line width register is
// written through cfg_valid/cfg_ready/cfg_data, which is always ready.
//
// A request lands in a holding register and is worked on once the result
// register is free to take what it yields. A repeat value byte is taken in
// a step of its own and then yields ceil(k/2) results for a run of k bytes,
// because the single result register takes one pair per cycle while the
// receiver takes results.
//
// After reset no scanline is active, the width is 32768 and both channels are
// empty. When the receiver stalls, the result register holds its result and
// the holding register still takes one more request; after that item_ready
// stays low until the result is taken.
module packbits_scanline_decoder
    import pbsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        mode,
    input  logic [7:0]  packed_byte,
    input  logic [15:0] line_bytes,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte,
    output logic [1:0]  byte_count,
    output logic [14:0] column,
    output logic        last,
    output logic        line_done,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    pbsd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    pbsd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .packed_byte (packed_byte),
        .line_bytes  (line_bytes),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .byte_count  (byte_count),
        .column      (column),
        .last        (last),
        .line_done   (line_done),
        .status      (status)
    );

endmodule
